// ----- rtl/aes_pkg.sv -----
// Package for the AES-128 CBC block: state type, S-box tables, round constants.
// GF(2^8) helpers and round functions used by the datapath and key expander.
// No dependencies.
package aes_pkg;

	localparam int unsigned KeyWords = 44;
	localparam int unsigned RkAddrW = 6;
	localparam int unsigned RegIdxW = 2;

	localparam logic [63:0] KeyHighReset = 64'h6d656e6779617975;
	localparam logic [63:0] KeyLowReset = 64'h616e000000000000;
	localparam logic [63:0] IvHighReset = 64'h3132330000000000;
	localparam logic [63:0] IvLowReset = 64'h0;

	localparam logic [RegIdxW-1:0] RegKeyHigh = 2'd0;
	localparam logic [RegIdxW-1:0] RegKeyLow = 2'd1;
	localparam logic [RegIdxW-1:0] RegIvHigh = 2'd2;
	localparam logic [RegIdxW-1:0] RegIvLow = 2'd3;

	localparam logic CmdEncrypt = 1'b0;
	localparam logic CmdDecrypt = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIRST,
		ST_ROUND,
		ST_OUT
	} core_state_t;

	typedef enum logic [1:0] {
		KX_IDLE,
		KX_RUN
	} kx_state_t;

	typedef logic [7:0] sbox_t [256];

	localparam sbox_t Sbox = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

	localparam sbox_t InvSbox = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

	function automatic logic [7:0] rcon(input logic [3:0] idx);
		logic [7:0] r;
		case (idx)
			4'd0: r = 8'h01;
			4'd1: r = 8'h02;
			4'd2: r = 8'h04;
			4'd3: r = 8'h08;
			4'd4: r = 8'h10;
			4'd5: r = 8'h20;
			4'd6: r = 8'h40;
			4'd7: r = 8'h80;
			4'd8: r = 8'h1b;
			4'd9: r = 8'h36;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] xt(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {Sbox[w[31:24]], Sbox[w[23:16]], Sbox[w[15:8]], Sbox[w[7:0]]};
	endfunction

	// Byte i of the block sits at bits 127-8i; byte index is 4*column + row.
	function automatic logic [7:0] gb(input logic [127:0] s, input int i);
		return s[127-8*i -: 8];
	endfunction

	function automatic logic [127:0] enc_sub_shift(input logic [127:0] s);
		logic [127:0] o;
		o = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				o[127-8*(4*c+r) -: 8] = Sbox[gb(s, 4*((c+r)%4)+r)];
			end
		end
		return o;
	endfunction

	function automatic logic [127:0] dec_sub_shift(input logic [127:0] s);
		logic [127:0] o;
		o = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				o[127-8*(4*c+r) -: 8] = InvSbox[gb(s, 4*((c+4-r)%4)+r)];
			end
		end
		return o;
	endfunction

	function automatic logic [127:0] mix_fwd(input logic [127:0] s);
		logic [127:0] o;
		logic [7:0] a0, a1, a2, a3;
		o = '0;
		for (int c = 0; c < 4; c++) begin
			a0 = gb(s, 4*c); a1 = gb(s, 4*c+1); a2 = gb(s, 4*c+2); a3 = gb(s, 4*c+3);
			o[127-8*(4*c) -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
			o[127-8*(4*c+1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
			o[127-8*(4*c+2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
			o[127-8*(4*c+3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
		end
		return o;
	endfunction

	// Inverse mix as a 5-0-4-0 preconditioning followed by the forward mix.
	function automatic logic [127:0] mix_inv(input logic [127:0] s);
		logic [127:0] p;
		logic [7:0] a0, a1, a2, a3, u, v;
		p = '0;
		for (int c = 0; c < 4; c++) begin
			a0 = gb(s, 4*c); a1 = gb(s, 4*c+1); a2 = gb(s, 4*c+2); a3 = gb(s, 4*c+3);
			u = xt(xt(a0 ^ a2));
			v = xt(xt(a1 ^ a3));
			p[127-8*(4*c) -: 8] = a0 ^ u;
			p[127-8*(4*c+1) -: 8] = a1 ^ v;
			p[127-8*(4*c+2) -: 8] = a2 ^ u;
			p[127-8*(4*c+3) -: 8] = a3 ^ v;
		end
		return mix_fwd(p);
	endfunction

endpackage

// ----- rtl/aes_ram.sv -----
// Generic single-port-write, single-port-read synchronous RAM with registered read.
// No dependencies.
module aes_ram #(
	parameter int unsigned Width = 32,
	parameter int unsigned Depth = 44
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(Depth)-1:0] wr_addr,
	input  logic [Width-1:0]         wr_data,
	input  logic [$clog2(Depth)-1:0] rd_addr,
	output logic [Width-1:0]         rd_data
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ----- rtl/aes_keyexp.sv -----
// Key expander: writes the 44 round key words into the key RAM, one word a cycle.
// Depends on aes_pkg.
module aes_keyexp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [63:0]                key_high,
	input  logic [63:0]                key_low,
	output logic                       busy,
	output logic                       wr_en,
	output logic [aes_pkg::RkAddrW-1:0] wr_addr,
	output logic [31:0]                wr_data
);

	aes_pkg::kx_state_t state_q, state_d;
	logic [aes_pkg::RkAddrW-1:0] idx_q;
	// Sliding window of the last four words written.
	logic [31:0] w_q [4];
	logic [31:0] t, nw;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			aes_pkg::KX_IDLE: if (start) state_d = aes_pkg::KX_RUN;
			aes_pkg::KX_RUN: begin
				if (start) state_d = aes_pkg::KX_RUN;
				else if (idx_q == aes_pkg::RkAddrW'(aes_pkg::KeyWords - 1)) state_d = aes_pkg::KX_IDLE;
			end
			default: state_d = aes_pkg::KX_IDLE;
		endcase
	end

	always_comb begin
		t = w_q[3];
		if (idx_q[1:0] == 2'd0) begin
			t = aes_pkg::sub_word({w_q[3][23:0], w_q[3][31:24]})
				^ {aes_pkg::rcon(4'(idx_q[5:2] - 4'd1)), 24'h0};
		end
		if (idx_q < aes_pkg::RkAddrW'(4)) begin
			case (idx_q[1:0])
				2'd0: nw = key_high[63:32];
				2'd1: nw = key_high[31:0];
				2'd2: nw = key_low[63:32];
				default: nw = key_low[31:0];
			endcase
		end else begin
			nw = w_q[0] ^ t;
		end
	end

	always_comb begin
		busy = (state_q == aes_pkg::KX_RUN) || start;
		wr_en = (state_q == aes_pkg::KX_RUN) && !start;
		wr_addr = idx_q;
		wr_data = nw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aes_pkg::KX_RUN;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (start) idx_q <= '0;
			else if (state_q == aes_pkg::KX_RUN) idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == aes_pkg::KX_RUN && !start) begin
			w_q[0] <= w_q[1];
			w_q[1] <= w_q[2];
			w_q[2] <= w_q[3];
			w_q[3] <= nw;
		end
	end

endmodule

// ----- rtl/aes_core.sv -----
// Round datapath and sequencer: one block at a time, round keys read word by word from the key RAM.
// Depends on aes_pkg.
module aes_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        cmd,
	input  logic                        chain_start,
	input  logic [127:0]                blk,
	input  logic [127:0]                iv,
	input  logic                        hold,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [127:0]                res,
	output logic [aes_pkg::RkAddrW-1:0] rk_addr,
	input  logic [31:0]                 rk_data
);

	aes_pkg::core_state_t state_q, state_d;
	logic [3:0] round_q;
	logic [1:0] word_q;
	logic cmd_q;
	logic [127:0] st_q, chain_q, cin_q, key_q, res_q;
	logic [127:0] rnd, rnd_key, full_key;
	logic [3:0] key_round;
	logic out_valid_q, load_key;
	logic fetch_d_q;
	logic [1:0] fetch_w_q;
	logic fin_q, first_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			aes_pkg::ST_IDLE: if (in_valid && in_ready) state_d = aes_pkg::ST_FIRST;
			aes_pkg::ST_FIRST: if (word_q == 2'd3) state_d = aes_pkg::ST_ROUND;
			aes_pkg::ST_ROUND: if (round_q == 4'd10 && word_q == 2'd3) state_d = aes_pkg::ST_OUT;
			aes_pkg::ST_OUT: if (out_valid_q && out_ready) state_d = aes_pkg::ST_IDLE;
			default: state_d = aes_pkg::ST_IDLE;
		endcase
	end

	// Each round fetches its four key words in turn; the round transform fires once the last has arrived.
	always_comb begin
		in_ready = (state_q == aes_pkg::ST_IDLE) && !hold;
		out_valid = out_valid_q;
		res = res_q;
		key_round = cmd_q ? 4'(4'd10 - round_q) : round_q;
		rk_addr = aes_pkg::RkAddrW'({key_round, 2'b00}) + aes_pkg::RkAddrW'(word_q);
		load_key = (state_q == aes_pkg::ST_FIRST) || (state_q == aes_pkg::ST_ROUND);
		if (!cmd_q) begin
			rnd = aes_pkg::enc_sub_shift(st_q);
			if (!fin_q) rnd = aes_pkg::mix_fwd(rnd);
		end else begin
			rnd = aes_pkg::dec_sub_shift(st_q);
		end
	end

	always_comb begin
		full_key = key_q;
		full_key[127-32*fetch_w_q -: 32] = rk_data;
		rnd_key = rnd ^ full_key;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aes_pkg::ST_IDLE;
			round_q <= '0;
			word_q <= '0;
			out_valid_q <= 1'b0;
			fetch_d_q <= 1'b0;
			fin_q <= 1'b0;
			chain_q <= {aes_pkg::IvHighReset, aes_pkg::IvLowReset};
		end else begin
			state_q <= state_d;
			fetch_d_q <= load_key;
			fin_q <= (state_q == aes_pkg::ST_ROUND) && round_q == 4'd10 && word_q == 2'd3;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			if (in_valid && in_ready) begin
				round_q <= '0;
				word_q <= '0;
			end else if (load_key) begin
				word_q <= word_q + 1'b1;
				if (word_q == 2'd3) round_q <= round_q + 1'b1;
			end
			if (fin_q) out_valid_q <= 1'b1;
			if (in_valid && in_ready && chain_start) chain_q <= iv;
			else if (fin_q) chain_q <= cmd_q ? cin_q : rnd_key;
		end
	end

	// Payload: key words arrive in the cycle after their address; a round applies once
	// its fourth word has landed.
	always_ff @(posedge clk) begin
		fetch_w_q <= word_q;
		first_q <= (state_q == aes_pkg::ST_FIRST);
		if (fetch_d_q) key_q <= full_key;
		if (in_valid && in_ready) begin
			cmd_q <= cmd;
			cin_q <= blk;
			if (cmd == aes_pkg::CmdEncrypt) st_q <= blk ^ (chain_start ? iv : chain_q);
			else st_q <= blk;
		end else if (fetch_d_q && fetch_w_q == 2'd3) begin
			if (first_q) st_q <= st_q ^ full_key;
			else if (cmd_q && !fin_q) st_q <= aes_pkg::mix_inv(rnd_key);
			else st_q <= rnd_key;
		end
		if (fin_q) begin
			res_q <= cmd_q ? (rnd_key ^ chain_q) : rnd_key;
		end
	end

endmodule

// ----- rtl/aes128_cbc_block_cipher.sv -----
// AES-128 CBC block cipher, top level: configuration registers, key RAM, key
// expander and round core. Depends on aes_pkg, aes_ram, aes_keyexp, aes_core.
// One block at a time: the next input transfer is taken once the result has left the
// output register and the key expander is not busy.
// The round loop fetches one 32-bit round key word a cycle from the single key RAM
// port, so each of the eleven key additions waits for all four of its words.
// Reset: asynchronous, active low; loads the default key and IV, then the key
// expander fills the key RAM with all 44 words, during which no input transfer is taken.
module aes128_cbc_block_cipher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic        chain_start,
	input  logic [63:0] block_high,
	input  logic [63:0] block_low,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] result_high,
	output logic [63:0] result_low
);

	logic [63:0] key_high_q, key_low_q, iv_high_q, iv_low_q;
	logic cfg_fire, key_write, kx_busy, kx_wr;
	logic [aes_pkg::RkAddrW-1:0] kx_addr, rk_addr;
	logic [31:0] kx_data, rk_data;
	logic [127:0] res;

	// Configuration is always taken; a key write restarts the expansion.
	assign cfg_ready = 1'b1;
	assign cfg_fire = cfg_valid && cfg_ready;
	assign key_write = cfg_fire
		&& (cfg_index == aes_pkg::RegKeyHigh || cfg_index == aes_pkg::RegKeyLow);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= aes_pkg::KeyHighReset;
			key_low_q <= aes_pkg::KeyLowReset;
			iv_high_q <= aes_pkg::IvHighReset;
			iv_low_q <= aes_pkg::IvLowReset;
		end else if (cfg_fire) begin
			unique case (cfg_index)
				aes_pkg::RegKeyHigh: key_high_q <= cfg_data;
				aes_pkg::RegKeyLow: key_low_q <= cfg_data;
				aes_pkg::RegIvHigh: iv_high_q <= cfg_data;
				aes_pkg::RegIvLow: iv_low_q <= cfg_data;
				default: ;
			endcase
		end
	end

	aes_keyexp u_keyexp (
		.clk(clk), .arst_n(arst_n), .start(key_write),
		.key_high(key_high_q), .key_low(key_low_q),
		.busy(kx_busy), .wr_en(kx_wr), .wr_addr(kx_addr), .wr_data(kx_data)
	);

	aes_ram #(.Width(32), .Depth(aes_pkg::KeyWords)) u_key_ram (
		.clk(clk), .wr_en(kx_wr), .wr_addr(kx_addr), .wr_data(kx_data),
		.rd_addr(rk_addr), .rd_data(rk_data)
	);

	aes_core u_core (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(command), .chain_start(chain_start),
		.blk({block_high, block_low}), .iv({iv_high_q, iv_low_q}),
		.hold(kx_busy),
		.out_valid(out_valid), .out_ready(out_ready), .res(res),
		.rk_addr(rk_addr), .rk_data(rk_data)
	);

	assign result_high = res[127:64];
	assign result_low = res[63:0];

endmodule
